### rtl/msl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// msl_pkg: shared types and constants of the station sighting table
// Word layouts of the request and response channels, field widths and the
// command and status groups between controller and datapath.
// -----------------------------------------------------------------------------
package msl_pkg;

   // field widths
   localparam int ADDR_W = 48;
   localparam int DBM_W  = 8;
   localparam int FREQ_W = 13;
   localparam int TIME_W = 32;
   localparam int CHAN_W = 10;
   localparam int AGE_W  = 31;

   // default number of table entries
   localparam int DEFAULT_TABLE_DEPTH = 16;

   // request word: one sighting
   typedef struct packed {
      logic [ADDR_W-1:0]        station_addr;
      logic signed [DBM_W-1:0]  signal_dbm;
      logic [FREQ_W-1:0]        freq_mhz;
      logic [TIME_W-1:0]        now_sec;
   } req_word_type;

   // response word: one table entry of the dump
   typedef struct packed {
      logic [ADDR_W-1:0]        entry_addr;
      logic signed [DBM_W-1:0]  entry_dbm;
      logic [TIME_W-1:0]        entry_time;
      logic [CHAN_W-1:0]        entry_channel;
      logic                     last_entry;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;     // capture the accepted sighting
      logic scan_start;   // rewind the rank scan
      logic search_en;    // scan looks for the station
      logic merge_en;     // scan copies the table into the other bank in new order
      logic dump_en;      // scan emits the table
      logic commit;       // swap banks and take the aged count
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic drained;      // every rank read and consumed
      logic placed;       // touched entry written into the new order
      logic keep_zero;    // table empty after ageing
   } dp_status_type;

endpackage
`default_nettype wire

### rtl/msl_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// msl_chan_if: valid/ready channel
// Carries one word of the given payload type per handshake.
// -----------------------------------------------------------------------------
interface msl_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/msl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// msl_ctrl: phase sequencer of the sighting table
// Steps each sighting through search, reorder and dump, driving the datapath
// by commands and following its status.
// -----------------------------------------------------------------------------
module msl_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  msl_pkg::dp_status_type      status,
   output msl_pkg::dp_cmd_type         cmd
);
   import msl_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_MERGE  = 2'd2;
   localparam logic [1:0] ST_DUMP   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req   = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_en = 1'b1;
            if (status.drained) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_MERGE;
            end
         end
         ST_MERGE: begin
            cmd.merge_en = 1'b1;
            if (status.drained && status.placed) begin
               cmd.commit     = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = status.keep_zero ? ST_IDLE : ST_DUMP;
            end
         end
         ST_DUMP: begin
            cmd.dump_en = 1'b1;
            if (status.drained) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

### rtl/msl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// msl_dpath: table storage and scan datapath
// Two banks of entries in one memory, kept newest first. A rank scan reads
// one entry a cycle unless stalled, to search, to copy into the other bank in new
// order with the touched entry inserted, and to dump via the output register.
// -----------------------------------------------------------------------------
module msl_dpath #(
   parameter int TABLE_DEPTH = msl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  msl_pkg::dp_cmd_type              cmd,
   output msl_pkg::dp_status_type           status,
   input  msl_pkg::req_word_type            req_data,
   input  wire logic                        csr_valid,
   input  wire logic [msl_pkg::AGE_W-1:0]   csr_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output msl_pkg::rsp_word_type            rsp_data
);
   import msl_pkg::*;

   localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int MEM_SIZE = 1 << (IDX_W + 1);

   // channel rule constants, division by 5 done by reciprocal
   localparam logic [FREQ_W-1:0] FREQ_BASE    = 13'd2412;
   localparam logic [FREQ_W-1:0] FREQ_SPECIAL = 13'd2484;
   localparam logic [CHAN_W-1:0] CHAN_SPECIAL = 10'd14;
   localparam logic [CHAN_W-1:0] CHAN_MAX     = 10'd943;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 18;
   localparam logic [RECIP_W-1:0] RECIP_5 = 16'd52429;
   localparam int PROD_W = FREQ_W + RECIP_W;
   localparam int QUO_W  = PROD_W - RECIP_SHIFT;

   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 31'd60;

   typedef struct packed {
      logic [ADDR_W-1:0]        addr;
      logic signed [DBM_W-1:0]  dbm;
      logic [CHAN_W-1:0]        channel;
      logic [TIME_W-1:0]        stamp;
   } entry_type;

   function automatic logic [CHAN_W-1:0] chan_of(input logic [FREQ_W-1:0] f);
      logic [FREQ_W-1:0] d;
      logic [PROD_W-1:0] prod;
      logic [QUO_W-1:0]  c;
      d    = f - FREQ_BASE;
      prod = PROD_W'(d) * PROD_W'(RECIP_5);
      c    = prod[PROD_W-1:RECIP_SHIFT] + QUO_W'(1);
      if (f == FREQ_SPECIAL) begin
         chan_of = CHAN_SPECIAL;
      end else if (f < FREQ_BASE) begin
         chan_of = CHAN_W'(1);
      end else if (c > QUO_W'(CHAN_MAX)) begin
         chan_of = CHAN_MAX;
      end else begin
         chan_of = CHAN_W'(c);
      end
   endfunction

   // table memory, bank select is the top address bit
   entry_type mem [0:MEM_SIZE-1];

   // configuration and table control
   logic [AGE_W-1:0]  age_limit_ff, age_limit_in;
   logic              bank_ff, bank_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // captured sighting
   req_word_type      req_ff, req_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   // rank scan
   logic [CNT_W-1:0]  iss_ff, iss_in;
   logic              rvld_ff, rvld_in;
   logic [IDX_W-1:0]  rtag_ff, rtag_in;
   entry_type         rdata_ff;

   // search result
   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   entry_type         old_ff, old_in;

   // reorder
   logic              placed_ff, placed_in;
   logic [IDX_W-1:0]  wr_ff, wr_in;
   logic [CNT_W-1:0]  keep_ff, keep_in;

   // output register
   logic              out_valid_ff, out_valid_in;
   rsp_word_type      out_ff, out_in;

   logic              scan_on, issue_ok, sink_ok, adv, consume;
   logic              upd, skip_en, is_skip, insert_now, tail_now, wr_en, keep_ok;
   logic [IDX_W-1:0]  skip_pos;
   entry_type         touched, wr_entry;

   // touched entry: signal and channel replaced on a miss, on an equal or
   // stronger sighting in the same second or on a later one of a known station
   always_comb begin
      upd = !hit_ff
         || ($signed(req_ff.signal_dbm) >= $signed(old_ff.dbm) && old_ff.stamp == req_ff.now_sec)
         || (req_ff.now_sec > old_ff.stamp);
      touched.addr    = req_ff.station_addr;
      touched.dbm     = upd ? req_ff.signal_dbm : old_ff.dbm;
      touched.channel = upd ? chan_ff : old_ff.channel;
      touched.stamp   = req_ff.now_sec;
   end

   // scan flow control
   always_comb begin
      scan_on    = cmd.search_en | cmd.merge_en | cmd.dump_en;
      issue_ok   = scan_on && (iss_ff < count_ff);
      skip_en    = hit_ff || (count_ff == CNT_W'(TABLE_DEPTH));
      skip_pos   = hit_ff ? pos_ff : IDX_W'(TABLE_DEPTH - 1);
      is_skip    = skip_en && (rtag_ff == skip_pos);
      insert_now = cmd.merge_en && rvld_ff && !placed_ff && !is_skip
                   && (rdata_ff.stamp <= req_ff.now_sec);
      if (cmd.dump_en) begin
         sink_ok = !out_valid_ff || rsp_ready;
      end else if (cmd.merge_en) begin
         sink_ok = !insert_now;
      end else begin
         sink_ok = 1'b1;
      end
      adv     = !rvld_ff || sink_ok;
      consume = rvld_ff && sink_ok;
      status.drained   = (iss_ff >= count_ff) && !rvld_ff;
      status.placed    = placed_ff;
      status.keep_zero = (keep_ff == '0);
   end

   // write into the other bank in new order, touched entry ahead of the
   // first entry not newer than it, or at the end
   always_comb begin
      tail_now = cmd.merge_en && status.drained && !placed_ff;
      wr_en    = insert_now || tail_now || (cmd.merge_en && consume && !is_skip);
      wr_entry = (insert_now || tail_now) ? touched : rdata_ff;
      // tail entries past the age limit are dropped; a future stamp has age zero
      keep_ok  = (req_ff.now_sec < wr_entry.stamp)
              || ((req_ff.now_sec - wr_entry.stamp) <= {1'b0, age_limit_ff});
   end

   // next values
   always_comb begin
      age_limit_in = csr_valid ? csr_data : age_limit_ff;
      bank_in      = cmd.commit ? !bank_ff : bank_ff;
      count_in     = cmd.commit ? keep_ff : count_ff;
      req_in       = cmd.load_req ? req_data : req_ff;
      chan_in      = chan_of(req_ff.freq_mhz);

      iss_in  = iss_ff;
      rvld_in = rvld_ff;
      rtag_in = rtag_ff;
      if (cmd.scan_start) begin
         iss_in  = '0;
         rvld_in = 1'b0;
      end else if (adv) begin
         rvld_in = issue_ok;
         rtag_in = iss_ff[IDX_W-1:0];
         iss_in  = iss_ff + CNT_W'(issue_ok);
      end

      hit_in = hit_ff;
      pos_in = pos_ff;
      old_in = old_ff;
      if (cmd.load_req) begin
         hit_in = 1'b0;
      end else if (cmd.search_en && consume && !hit_ff
                   && rdata_ff.addr == req_ff.station_addr) begin
         hit_in = 1'b1;
         pos_in = rtag_ff;
         old_in = rdata_ff;
      end

      placed_in = placed_ff;
      wr_in     = wr_ff;
      keep_in   = keep_ff;
      if (cmd.load_req) begin
         placed_in = 1'b0;
         wr_in     = '0;
         keep_in   = '0;
      end else if (wr_en) begin
         wr_in = wr_ff + IDX_W'(1);
         if (insert_now || tail_now) begin
            placed_in = 1'b1;
         end
         if (keep_ok) begin
            keep_in = CNT_W'(wr_ff) + CNT_W'(1);
         end
      end

      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (cmd.dump_en && consume) begin
         out_valid_in         = 1'b1;
         out_in.entry_addr    = rdata_ff.addr;
         out_in.entry_dbm     = rdata_ff.dbm;
         out_in.entry_time    = rdata_ff.stamp;
         out_in.entry_channel = rdata_ff.channel;
         out_in.last_entry    = (CNT_W'(rtag_ff) + CNT_W'(1)) == count_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RESET;
         bank_ff      <= 1'b0;
         count_ff     <= '0;
         iss_ff       <= '0;
         rvld_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         placed_ff    <= 1'b0;
         wr_ff        <= '0;
         keep_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         age_limit_ff <= age_limit_in;
         bank_ff      <= bank_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         rvld_ff      <= rvld_in;
         hit_ff       <= hit_in;
         placed_ff    <= placed_in;
         wr_ff        <= wr_in;
         keep_ff      <= keep_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      chan_ff <= chan_in;
      rtag_ff <= rtag_in;
      pos_ff  <= pos_in;
      old_ff  <= old_in;
      out_ff  <= out_in;
   end

   // memory: one write to the spare bank, one registered read of the live bank
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{!bank_ff, wr_ff}] <= wr_entry;
      end
      if (adv && issue_ok && !cmd.scan_start) begin
         rdata_ff <= mem[{bank_ff, iss_ff[IDX_W-1:0]}];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

### rtl/mac_sighting_lru_table.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mac_sighting_lru_table: table of recently sighted stations
// Keeps up to TABLE_DEPTH stations newest first, updates or adds the sighted
// one, drops stale tail entries and dumps the whole table per sighting.
//
//   channel    dir  word                       handshake
//   req_chan   in   station, dbm, freq, time   valid/ready
//   rsp_chan   out  one entry, last flag       valid/ready
//   csr_chan   in   age limit in seconds       valid/ready, always ready
//
// A sighting is accepted and searched for in a rank-by-rank pass; the table
// is then copied into the spare bank with the touched entry written in and,
// unless it has aged out empty, dumped in a pass of one word a cycle. The
// passes run one after another on the single read port of the table memory,
// and the next sighting is accepted only once the last pass is through.
// Stalls on rsp_chan hold the dump pass.
// Reset leaves an empty table and an age limit of 60 seconds; no clearing pass.
// -----------------------------------------------------------------------------
module mac_sighting_lru_table #(
   parameter int TABLE_DEPTH = msl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   msl_chan_if.sink    req_chan,
   msl_chan_if.source  rsp_chan,
   msl_chan_if.sink    csr_chan
);
   import msl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;
   logic          rsp_valid;
   rsp_word_type  rsp_data;

   // sequencer
   msl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // storage and scan
   msl_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_chan.data),
      .csr_valid (csr_chan.valid),
      .csr_data  (csr_chan.data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_data)
   );

   // channel hookup
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.data  = rsp_data;

   // banks swap only once the touched entry is in the new order
   a_commit_placed: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.placed)
      else $error("bank swap before the touched entry was written");

   // every new sighting starts with the touched entry still to be placed
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |=> !status.placed)
      else $error("touched entry marked placed at start of a sighting");

   // a result word appears only out of the dump pass
   a_rsp_from_dump: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.dump_en))
      else $error("result word offered outside the dump pass");

endmodule
`default_nettype wire

### tb/mac_sighting_lru_table_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mac_sighting_lru_table_tb: self-checking bench for the station sighting table
// Sends sightings on the request channel and keeps its own copy of the table,
// newest first, to work out every entry of each dump. Each response word is
// compared field by field with the oldest expected entry. Directed sightings
// hit the field extremes, the update rules, eviction from a full table and
// time going backwards. Random phases follow under several age limits, with
// idle gaps on the sender and stalls on the receiver.
// -----------------------------------------------------------------------------
module mac_sighting_lru_table_tb;
   import msl_pkg::*;

   localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
   localparam int FREQ_CH14      = 2484;
   localparam int CH14           = 14;
   localparam int FREQ_BASE      = 2412;
   localparam int CH_SPACING     = 5;
   localparam int CH_MAX         = 943;
   localparam int RESET_AGE      = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int POOL_SIZE      = 20;

   typedef struct {
      logic [ADDR_W-1:0]       addr;
      logic signed [DBM_W-1:0] dbm;
      logic [CHAN_W-1:0]       chan;
      logic [TIME_W-1:0]       seen;
   } station_entry_type;

   logic clock;
   logic reset;

   msl_chan_if #(.payload_type(req_word_type))      req_if ();
   msl_chan_if #(.payload_type(rsp_word_type))      rsp_if ();
   msl_chan_if #(.payload_type(logic [AGE_W-1:0]))  csr_if ();

   mac_sighting_lru_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_chan  (csr_if)
   );

   // predicted table, newest first, and the dump words still to come
   station_entry_type sight_table [TABLE_DEPTH];
   int                sight_count;
   logic [AGE_W-1:0]  age_limit_model;
   rsp_word_type      expected_entries [$];

   int                error_count;
   int                send_idle_pct;
   int                recv_stall_pct;
   int                stall_counter;
   logic [ADDR_W-1:0] mac_pool [POOL_SIZE];
   logic [TIME_W-1:0] cur_time;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // channel number of a carrier frequency
   function automatic logic [CHAN_W-1:0] channel_of(input logic [FREQ_W-1:0] f);
      int c;
      if (f == FREQ_CH14) return CHAN_W'(CH14);
      if (f < FREQ_BASE) return CHAN_W'(1);
      c = (int'(f) - FREQ_BASE) / CH_SPACING + 1;
      return (c > CH_MAX) ? CHAN_W'(CH_MAX) : CHAN_W'(c);
   endfunction

   // update the table for one accepted sighting and queue its dump
   function automatic void predict_sighting(input req_word_type w);
      int                pos;
      int                k;
      int                i;
      station_entry_type moved;
      logic [TIME_W-1:0] age;
      rsp_word_type      r;
      pos = -1;
      for (i = 0; i < sight_count; i++) begin
         if (sight_table[i].addr == w.station_addr) begin
            pos = i;
            break;
         end
      end
      if (pos >= 0) begin
         if ((w.signal_dbm >= sight_table[pos].dbm && sight_table[pos].seen == w.now_sec)
             || w.now_sec > sight_table[pos].seen) begin
            sight_table[pos].dbm  = w.signal_dbm;
            sight_table[pos].chan = channel_of(w.freq_mhz);
         end
         sight_table[pos].seen = w.now_sec;
      end else begin
         if (sight_count < TABLE_DEPTH) begin
            pos = sight_count;
            sight_count++;
         end else begin
            pos = TABLE_DEPTH - 1;
         end
         sight_table[pos].addr = w.station_addr;
         sight_table[pos].dbm  = w.signal_dbm;
         sight_table[pos].chan = channel_of(w.freq_mhz);
         sight_table[pos].seen = w.now_sec;
      end
      // pull the touched entry out, reinsert ahead of equal or older entries
      moved = sight_table[pos];
      for (i = pos; i + 1 < sight_count; i++) sight_table[i] = sight_table[i + 1];
      k = sight_count - 1;
      for (i = 0; i + 1 < sight_count; i++) begin
         if (sight_table[i].seen <= moved.seen) begin
            k = i;
            break;
         end
      end
      for (i = sight_count - 1; i > k; i--) sight_table[i] = sight_table[i - 1];
      sight_table[k] = moved;
      // drop stale tail entries, an entry from the future has age zero
      while (sight_count > 0) begin
         age = (w.now_sec >= sight_table[sight_count - 1].seen) ?
               w.now_sec - sight_table[sight_count - 1].seen : '0;
         if (age > {1'b0, age_limit_model}) sight_count--;
         else break;
      end
      for (i = 0; i < sight_count; i++) begin
         r.entry_addr    = sight_table[i].addr;
         r.entry_dbm     = sight_table[i].dbm;
         r.entry_time    = sight_table[i].seen;
         r.entry_channel = sight_table[i].chan;
         r.last_entry    = (i + 1 == sight_count);
         expected_entries.push_back(r);
      end
   endfunction

   task automatic report_error(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // send one sighting word, with random idle cycles ahead of it
   task automatic send_sighting(input logic [ADDR_W-1:0] addr, input logic [DBM_W-1:0] dbm,
                                input logic [FREQ_W-1:0] freq, input logic [TIME_W-1:0] now);
      req_word_type w;
      w.station_addr = addr;
      w.signal_dbm   = dbm;
      w.freq_mhz     = freq;
      w.now_sec      = now;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      do @(posedge clock); while (!req_if.ready);
      predict_sighting(w);
      @(negedge clock);
   endtask

   // sender holds off until every expected entry has come back
   task automatic drain_entries();
      req_if.valid <= 1'b0;
      while (expected_entries.size() != 0) @(negedge clock);
   endtask

   // age limit write, only with the table idle
   task automatic set_age_limit(input logic [AGE_W-1:0] limit);
      drain_entries();
      repeat (8) @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data  <= limit;
      do @(posedge clock); while (!csr_if.ready);
      age_limit_model = limit;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // extremes of the address, signal and frequency fields on fresh stations
   task automatic test_field_extremes();
      send_sighting(48'h0000_0000_0000, 8'h80, 13'd0,    32'd0);
      send_sighting(48'hFFFF_FFFF_FFFF, 8'h7F, 13'h1FFF, 32'd0);
      send_sighting(48'h5555_5555_5555, 8'h00, 13'd2484, 32'd1);
      send_sighting(48'hAAAA_AAAA_AAAA, 8'hFF, 13'd2412, 32'd1);
      send_sighting(48'h1234_5678_9ABC, 8'hC4, 13'd7125, 32'd2);
      send_sighting(48'h0000_0000_0001, 8'hD8, 13'd2411, 32'd2);
   endtask

   // signal and channel replacement rules on a known station
   task automatic test_update_rules();
      // time advanced, weaker signal still replaces
      send_sighting(48'h5555_5555_5555, 8'hEC, 13'd2437, 32'd2);
      // same second, weaker signal is ignored
      send_sighting(48'h5555_5555_5555, 8'hE2, 13'd2462, 32'd2);
      // same second, equal signal replaces
      send_sighting(48'h5555_5555_5555, 8'hEC, 13'd5180, 32'd2);
      // time going backwards keeps the signal but takes the new time
      send_sighting(48'h5555_5555_5555, 8'h32, 13'd2413, 32'd1);
   endtask

   // fill the table and push out the oldest entry
   task automatic test_table_full();
      int i;
      for (i = 0; i < 11; i++)
         send_sighting(48'h0200_5E00_0000 | i, 8'($urandom), 13'(FREQ_BASE + 5 * i), 32'd3);
   endtask

   // time jumps to the top, everything else ages out, then time goes backwards
   task automatic test_time_wrap();
      send_sighting(48'h00C0_FFEE_0001, 8'h10, 13'd5955, 32'hFFFF_FFFF);
      send_sighting(48'h00C0_FFEE_0002, 8'hF0, 13'd6000, 32'd0);
   endtask

   // random sightings, mostly from a pool of stations, with a clock that mostly holds or advances
   task automatic test_random_sightings(input int n_items, input int send_idle,
                                        input int recv_stall, input logic [AGE_W-1:0] limit);
      int                i;
      int                sel;
      logic [ADDR_W-1:0] addr;
      logic [FREQ_W-1:0] freq;
      set_age_limit(limit);
      send_idle_pct  = send_idle;
      recv_stall_pct = recv_stall;
      for (i = 0; i < POOL_SIZE; i++) mac_pool[i] = {16'($urandom), 32'($urandom)};
      cur_time = $urandom;
      for (i = 0; i < n_items; i++) begin
         // one pause per phase until the table has caught up
         if (i == n_items / 2) drain_entries();
         sel = $urandom_range(99);
         if (sel < 50) cur_time = cur_time;
         else if (sel < 85) cur_time = cur_time + $urandom_range(1, 3);
         else if (sel < 93) cur_time = cur_time + $urandom_range(4, 100);
         else if (sel < 97) cur_time = $urandom;
         else cur_time = cur_time - $urandom_range(1, 10);
         addr = ($urandom_range(99) < 85) ? mac_pool[$urandom_range(POOL_SIZE - 1)]
                                          : {16'($urandom), 32'($urandom)};
         sel = $urandom_range(99);
         if (sel < 30) freq = 13'(FREQ_BASE + CH_SPACING * $urandom_range(0, 12));
         else if (sel < 35) freq = 13'(FREQ_CH14);
         else if (sel < 60) freq = 13'(5180 + 20 * $urandom_range(0, 40));
         else freq = 13'($urandom_range(8191));
         send_sighting(addr, 8'($urandom), freq, cur_time);
      end
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each dump word with the oldest expected entry
   always @(posedge clock) begin : entry_check
      rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_entries.size() == 0) begin
            report_error($sformatf("unexpected word for station %0h", rsp_if.data.entry_addr));
         end else begin
            want = expected_entries.pop_front();
            check_field("entry_addr",    rsp_if.data.entry_addr,    want.entry_addr);
            check_field("entry_dbm",     rsp_if.data.entry_dbm,     want.entry_dbm);
            check_field("entry_time",    rsp_if.data.entry_time,    want.entry_time);
            check_field("entry_channel", rsp_if.data.entry_channel, want.entry_channel);
            check_field("last_entry",    rsp_if.data.last_entry,    want.last_entry);
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         stall_counter <= 0;
      end else if (stall_counter >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_counter <= stall_counter + 1;
      end
   end

   // sequence of tests
   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.data     = '0;
      csr_if.valid    = 1'b0;
      csr_if.data     = '0;
      rsp_if.ready    = 1'b0;
      error_count     = 0;
      stall_counter   = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      sight_count     = 0;
      age_limit_model = AGE_W'(RESET_AGE);
      cur_time        = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_update_rules();
      test_table_full();
      test_time_wrap();

      test_random_sightings(68, 0,  0,  AGE_W'(RESET_AGE));
      test_random_sightings(68, 80, 0,  '0);
      test_random_sightings(68, 0,  80, '1);
      test_random_sightings(68, 26, 26, AGE_W'(3));
      test_random_sightings(68, 26, 26, AGE_W'($urandom_range(1, 200)));
      test_random_sightings(20, 0,  0,  AGE_W'($urandom));

      drain_entries();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### mac_sighting_lru_table.f
rtl/msl_pkg.sv
rtl/msl_chan_if.sv
rtl/msl_ctrl.sv
rtl/msl_dpath.sv
rtl/mac_sighting_lru_table.sv
tb/mac_sighting_lru_table_tb.sv
